// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define MTT_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MTT_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MTT_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MTT_ASSERT(name, clk, rst, prop, msg)
`define MTT_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define MTT_ASSERT_NXT(name, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/mtt_pkg.sv =====
// Shared types and constants of the map text tokenizer.
package mtt_pkg;

  localparam int MAX_STRING_LENGTH_DEF = 255;
  localparam int MAX_IDENT_LENGTH_DEF  = 63;
  localparam int FIFO_DEPTH            = 4;

  localparam logic [3:0] KIND_INT    = 4'd0;
  localparam logic [3:0] KIND_FLOAT  = 4'd1;
  localparam logic [3:0] KIND_STRING = 4'd2;
  localparam logic [3:0] KIND_IDENT  = 4'd3;
  localparam logic [3:0] KIND_LBRACE = 4'd4;
  localparam logic [3:0] KIND_RBRACE = 4'd5;
  localparam logic [3:0] KIND_LPAREN = 4'd6;
  localparam logic [3:0] KIND_RPAREN = 4'd7;
  localparam logic [3:0] KIND_OTHER  = 4'd8;
  localparam logic [3:0] KIND_UNTERM = 4'd9;

  typedef struct packed {
    logic [3:0]         token_kind;
    logic [7:0]         token_length;
    logic signed [31:0] int_value;
    logic               overflow_flag;
    logic               last_result;
  } token_t;

  // Up to two results produced by one accepted byte.
  typedef struct packed {
    logic [1:0] num;
    token_t     res0;
    token_t     res1;
  } push_t;

endpackage

// ===== hdl/mtt_if.sv =====
// Channel interfaces: text bytes in, token records out.
interface mtt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface mtt_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         token_kind;
  logic [7:0]         token_length;
  logic signed [31:0] int_value;
  logic               overflow_flag;
  logic               last_result;

  modport source (output valid, output token_kind, output token_length, output int_value,
                  output overflow_flag, output last_result, input ready);
  modport sink   (input valid, input token_kind, input token_length, input int_value,
                  input overflow_flag, input last_result, output ready);
endinterface

// ===== hdl/map_text_tokenizer_unit.sv =====
// Map text tokenizer: one text byte per item in, token records out.
//
// text_in carries one byte (char_code) and a final-byte mark (last_char) per item.
// token_out carries one token record per item: kind, length, integer value,
// overflow flag and a mark on the final record caused by a byte with last_char set.
// A byte is scanned in the cycle it is accepted; its records (zero, one or two)
// enter a four-entry result queue at that edge and are handed out on token_out
// in order from the queue head. Input throughput is one byte per cycle while
// at least two queue entries are free; text_in.ready drops whenever fewer than
// two queue entries are free, so bytes wait while the queue is backed up. The
// output handshake sets the rate: one record per cycle at most.
// A stalled receiver holds the head record; bytes keep being taken until fewer
// than two queue entries are free. Synchronous reset returns the scanner to the
// between-tokens state and empties the queue. After a byte with last_char set,
// any open token is flushed and the scanner starts over from the reset state.
module map_text_tokenizer_unit #(
  parameter int MAX_STRING_LENGTH = mtt_pkg::MAX_STRING_LENGTH_DEF,
  parameter int MAX_IDENT_LENGTH  = mtt_pkg::MAX_IDENT_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  mtt_in_if.sink     text_in,
  mtt_out_if.source  token_out
);

  mtt_pkg::push_t push;
  logic           room;

  mtt_scan #(
    .MAX_STRING_LENGTH (MAX_STRING_LENGTH),
    .MAX_IDENT_LENGTH  (MAX_IDENT_LENGTH)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .text_in (text_in),
    .room    (room),
    .push    (push)
  );

  mtt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .token_out (token_out)
  );

endmodule

// ===== hdl/mtt_scan.sv =====
// Lexer state machine: scans one byte per cycle while room is high and produces up to two token records.
`include "assert_macros.svh"
module mtt_scan #(
  parameter int MAX_STRING_LENGTH = mtt_pkg::MAX_STRING_LENGTH_DEF,
  parameter int MAX_IDENT_LENGTH  = mtt_pkg::MAX_IDENT_LENGTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  mtt_in_if.sink          text_in,
  input  logic            room,
  output mtt_pkg::push_t  push
);

  localparam logic [3:0] M_NORMAL     = 4'd0;
  localparam logic [3:0] M_SLASH      = 4'd1;
  localparam logic [3:0] M_LINE       = 4'd2;
  localparam logic [3:0] M_BLOCK      = 4'd3;
  localparam logic [3:0] M_BLOCK_STAR = 4'd4;
  localparam logic [3:0] M_STRING     = 4'd5;
  localparam logic [3:0] M_IDENT      = 4'd6;
  localparam logic [3:0] M_NUM_SIGN   = 4'd7;
  localparam logic [3:0] M_NUM_INT    = 4'd8;
  localparam logic [3:0] M_NUM_FRAC   = 4'd9;
  localparam logic [3:0] M_NUM_EXP    = 4'd10;
  localparam logic [3:0] M_NUM_EXPDIG = 4'd11;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [7:0] STR_LIMIT   = 8'(MAX_STRING_LENGTH);
  localparam logic [7:0] IDENT_LIMIT = 8'(MAX_IDENT_LENGTH);
  localparam logic [7:0] NUM_LIMIT   = 8'd255;

  typedef struct packed {
    logic [3:0]  mode;
    logic [7:0]  cnt;
    logic [31:0] acc;
    logic        neg;
    logic        sat;
  } scan_t;

  typedef struct packed {
    scan_t            st;
    logic             hit;
    mtt_pkg::token_t  tok;
  } start_t;

  localparam scan_t SCAN_RESET = '{mode: M_NORMAL, cnt: 8'd0, acc: 32'd0, neg: 1'b0, sat: 1'b0};

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
  endfunction

  function automatic mtt_pkg::token_t mk(logic [3:0] kind, logic [7:0] len,
                                         logic [31:0] val, logic flag);
    mtt_pkg::token_t t;
    t.token_kind    = kind;
    t.token_length  = len;
    t.int_value     = val;
    t.overflow_flag = flag;
    t.last_result   = 1'b0;
    return t;
  endfunction

  function automatic scan_t grow(scan_t s, logic [7:0] limit);
    scan_t r;
    r = s;
    if (s.cnt >= limit) r.sat = 1'b1;
    else r.cnt = s.cnt + 8'd1;
    return r;
  endfunction

  // Multiply by ten as two shifted adds, then clamp at 2^31.
  function automatic scan_t add_digit(scan_t s, logic [7:0] c);
    scan_t       r;
    logic [35:0] m;
    r = s;
    m = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + {32'd0, c[3:0]};
    if (m > 36'h0_8000_0000) begin
      r.acc = 32'h8000_0000;
      r.sat = 1'b1;
    end else begin
      r.acc = m[31:0];
    end
    return r;
  endfunction

  function automatic mtt_pkg::token_t end_number(scan_t s);
    logic [31:0] val;
    logic        flag;
    if (s.mode == M_NUM_SIGN || s.mode == M_NUM_INT) begin
      flag = s.sat;
      if (s.neg) begin
        val = 32'd0 - s.acc;
      end else if (s.acc > 32'h7FFF_FFFF) begin
        val  = 32'h7FFF_FFFF;
        flag = 1'b1;
      end else begin
        val = s.acc;
      end
      return mk(mtt_pkg::KIND_INT, s.cnt, val, flag);
    end
    return mk(mtt_pkg::KIND_FLOAT, s.cnt, 32'd0, s.sat);
  endfunction

  function automatic start_t start_byte(logic [7:0] c);
    start_t r;
    r.st  = SCAN_RESET;
    r.hit = 1'b0;
    r.tok = mk(mtt_pkg::KIND_OTHER, 8'd1, 32'd0, 1'b0);
    if (c inside {8'h20, 8'h09, 8'h0A, 8'h0D}) begin
      r.hit = 1'b0;
    end else if (c == CH_SLASH) begin
      r.st.mode = M_SLASH;
    end else if (c == CH_QUOTE) begin
      r.st.mode = M_STRING;
    end else if (is_alpha(c)) begin
      r.st.mode = M_IDENT;
      r.st.cnt  = 8'd1;
    end else if (c == CH_MINUS) begin
      r.st.mode = M_NUM_SIGN;
      r.st.cnt  = 8'd1;
      r.st.neg  = 1'b1;
    end else if (is_digit(c)) begin
      r.st.mode = M_NUM_INT;
      r.st.cnt  = 8'd1;
      r.st.acc  = {28'd0, c[3:0]};
    end else begin
      r.hit = 1'b1;
      case (c)
        8'h7B:   r.tok.token_kind = mtt_pkg::KIND_LBRACE;
        8'h7D:   r.tok.token_kind = mtt_pkg::KIND_RBRACE;
        8'h28:   r.tok.token_kind = mtt_pkg::KIND_LPAREN;
        8'h29:   r.tok.token_kind = mtt_pkg::KIND_RPAREN;
        default: r.tok.token_kind = mtt_pkg::KIND_OTHER;
      endcase
    end
    return r;
  endfunction

  scan_t            st;
  scan_t            st_next;
  start_t           sb;
  mtt_pkg::token_t  res_v [2];
  logic [1:0]       n_v;
  logic             fire;
  logic [7:0]       c;

  assign text_in.ready = room;
  assign fire          = text_in.valid && room;
  assign c             = text_in.char_code;

  always_comb begin
    st_next  = st;
    n_v      = 2'd0;
    res_v[0] = '0;
    res_v[1] = '0;
    sb       = start_byte(c);

    case (st.mode)
      M_SLASH: begin
        if (c == CH_SLASH) begin
          st_next.mode = M_LINE;
        end else if (c == CH_STAR) begin
          st_next.mode = M_BLOCK;
        end else begin
          res_v[n_v[0]] = mk(mtt_pkg::KIND_OTHER, 8'd1, 32'd0, 1'b0);
          n_v = n_v + 2'd1;
          st_next = sb.st;
          if (sb.hit) begin
            res_v[n_v[0]] = sb.tok;
            n_v = n_v + 2'd1;
          end
        end
      end
      M_LINE: begin
        if (c == CH_LF) st_next.mode = M_NORMAL;
      end
      M_BLOCK: begin
        if (c == CH_STAR) st_next.mode = M_BLOCK_STAR;
      end
      M_BLOCK_STAR: begin
        if (c == CH_SLASH) st_next.mode = M_NORMAL;
        else if (c != CH_STAR) st_next.mode = M_BLOCK;
      end
      M_STRING: begin
        if (c == CH_QUOTE) begin
          res_v[n_v[0]] = mk(mtt_pkg::KIND_STRING, st.cnt, 32'd0, st.sat);
          n_v = n_v + 2'd1;
          st_next = SCAN_RESET;
        end else begin
          st_next = grow(st, STR_LIMIT);
        end
      end
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c)) begin
          st_next = grow(st, IDENT_LIMIT);
        end else begin
          res_v[n_v[0]] = mk(mtt_pkg::KIND_IDENT, st.cnt, 32'd0, st.sat);
          n_v = n_v + 2'd1;
          st_next = sb.st;
          if (sb.hit) begin
            res_v[n_v[0]] = sb.tok;
            n_v = n_v + 2'd1;
          end
        end
      end
      M_NUM_SIGN, M_NUM_INT, M_NUM_FRAC, M_NUM_EXP, M_NUM_EXPDIG: begin
        if ((st.mode == M_NUM_SIGN || st.mode == M_NUM_INT) && is_digit(c)) begin
          st_next      = grow(add_digit(st, c), NUM_LIMIT);
          st_next.mode = M_NUM_INT;
        end else if ((st.mode == M_NUM_SIGN || st.mode == M_NUM_INT) && c == CH_DOT) begin
          st_next      = grow(st, NUM_LIMIT);
          st_next.mode = M_NUM_FRAC;
        end else if (st.mode == M_NUM_FRAC && is_digit(c)) begin
          st_next = grow(st, NUM_LIMIT);
        end else if (st.mode == M_NUM_FRAC && c == CH_E) begin
          st_next      = grow(st, NUM_LIMIT);
          st_next.mode = M_NUM_EXP;
        end else if (st.mode == M_NUM_EXP && (is_digit(c) || c == CH_MINUS)) begin
          st_next      = grow(st, NUM_LIMIT);
          st_next.mode = M_NUM_EXPDIG;
        end else if (st.mode == M_NUM_EXPDIG && is_digit(c)) begin
          st_next = grow(st, NUM_LIMIT);
        end else begin
          // End the number and rescan this byte as the start of the next token.
          res_v[n_v[0]] = end_number(st);
          n_v = n_v + 2'd1;
          st_next = sb.st;
          if (sb.hit) begin
            res_v[n_v[0]] = sb.tok;
            n_v = n_v + 2'd1;
          end
        end
      end
      default: begin
        st_next = sb.st;
        if (sb.hit) begin
          res_v[n_v[0]] = sb.tok;
          n_v = n_v + 2'd1;
        end
      end
    endcase

    // Flush any open token on the final byte, then return to reset.
    if (text_in.last_char) begin
      case (st_next.mode)
        M_SLASH: begin
          res_v[n_v[0]] = mk(mtt_pkg::KIND_OTHER, 8'd1, 32'd0, 1'b0);
          n_v = n_v + 2'd1;
        end
        M_STRING: begin
          res_v[n_v[0]] = mk(mtt_pkg::KIND_UNTERM, st_next.cnt, 32'd0, st_next.sat);
          n_v = n_v + 2'd1;
        end
        M_BLOCK, M_BLOCK_STAR: begin
          res_v[n_v[0]] = mk(mtt_pkg::KIND_UNTERM, 8'd0, 32'd0, 1'b0);
          n_v = n_v + 2'd1;
        end
        M_IDENT: begin
          res_v[n_v[0]] = mk(mtt_pkg::KIND_IDENT, st_next.cnt, 32'd0, st_next.sat);
          n_v = n_v + 2'd1;
        end
        M_NUM_SIGN, M_NUM_INT, M_NUM_FRAC, M_NUM_EXP, M_NUM_EXPDIG: begin
          res_v[n_v[0]] = end_number(st_next);
          n_v = n_v + 2'd1;
        end
        default: begin
          n_v = n_v;
        end
      endcase
      if (n_v != 2'd0) res_v[1'(n_v - 2'd1)].last_result = 1'b1;
      st_next = SCAN_RESET;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= SCAN_RESET;
    end else if (fire) begin
      st <= st_next;
    end
  end

  assign push.num  = fire ? n_v : 2'd0;
  assign push.res0 = res_v[0];
  assign push.res1 = res_v[1];

  `MTT_ASSERT_NXT(a_last_resets, clk, rst, fire && text_in.last_char,
                  st.mode == M_NORMAL && st.cnt == 8'd0 && st.acc == 32'd0,
                  "scanner state not cleared after final byte")
  `MTT_ASSERT_IMP(a_last_on_final, clk, rst, push.num == 2'd2,
                  !push.res0.last_result, "last_result set on a result that is not final")
  `MTT_ASSERT(a_mode_legal, clk, rst, st.mode <= M_NUM_EXPDIG, "scanner mode out of range")
endmodule

// ===== hdl/mtt_fifo.sv =====
// Result queue: takes up to two token records per cycle, hands out one per cycle while token_out.ready is high.
`include "assert_macros.svh"
module mtt_fifo (
  input  logic            clk,
  input  logic            rst,
  input  mtt_pkg::push_t  push,
  output logic            room,
  mtt_out_if.source       token_out
);

  localparam int DEPTH = mtt_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mtt_pkg::token_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             pop;
  mtt_pkg::token_t  head;

  // Hold both channels idle while in reset.
  assign room = !rst && (count <= CNT_W'(DEPTH - 2));
  assign pop  = token_out.valid && token_out.ready;
  assign head = mem[rd_ptr];

  assign count_next = count + CNT_W'(push.num) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.num);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) mem[wr_ptr] <= push.res0;
    if (push.num == 2'd2) mem[wr_ptr + PTR_W'(1)] <= push.res1;
  end

  assign token_out.valid         = !rst && (count != '0);
  assign token_out.token_kind    = head.token_kind;
  assign token_out.token_length  = head.token_length;
  assign token_out.int_value     = head.int_value;
  assign token_out.overflow_flag = head.overflow_flag;
  assign token_out.last_result   = head.last_result;

  `MTT_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(DEPTH), "result queue overrun")
  `MTT_ASSERT_IMP(a_push_fits, clk, rst, push.num != 2'd0,
                  ({1'b0, count} + (CNT_W + 1)'(push.num)) <= (CNT_W + 1)'(DEPTH),
                  "push exceeds free queue space")
  `MTT_ASSERT_NXT(a_stall_holds, clk, rst, token_out.valid && !token_out.ready,
                  token_out.valid && count >= $past(count), "queued result lost under stall")
endmodule

// ===== test/tb.sv =====
// Testbench for map_text_tokenizer_unit: directed table, then random text, checked by a predictor and pinned results.
module tb;

  localparam int RANDOM_ITEMS = 1650;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 160;
  localparam int MAX_STR      = mtt_pkg::MAX_STRING_LENGTH_DEF;
  localparam int MAX_ID       = mtt_pkg::MAX_IDENT_LENGTH_DEF;
  localparam int MAX_NUM      = 255;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef enum logic [3:0] {
    SCAN_NORMAL, SCAN_SLASH, SCAN_LINE, SCAN_BLOCK, SCAN_BLOCK_STAR, SCAN_STRING,
    SCAN_IDENT, SCAN_SIGN, SCAN_INT, SCAN_FRAC, SCAN_EXP, SCAN_EXP_DIGIT
  } scan_e;

  typedef struct {
    logic [7:0] c;
    logic       last;
  } text_t;

  // pinned rows carry a result typed in by hand; the others go to the predictor
  typedef struct {
    logic [7:0]         c;
    logic               last;
    logic               pinned;
    logic [3:0]         kind;
    logic [7:0]         len;
    logic signed [31:0] val;
    logic               flag;
    logic               lastr;
  } dir_row_t;

  dir_row_t directed_tab [25] = '{
    '{"{",      1'b0, 1'b1, mtt_pkg::KIND_LBRACE, 8'd1, 32'sd0, 1'b0, 1'b0},
    '{"}",      1'b0, 1'b1, mtt_pkg::KIND_RBRACE, 8'd1, 32'sd0, 1'b0, 1'b0},
    '{"(",      1'b0, 1'b1, mtt_pkg::KIND_LPAREN, 8'd1, 32'sd0, 1'b0, 1'b0},
    '{")",      1'b0, 1'b1, mtt_pkg::KIND_RPAREN, 8'd1, 32'sd0, 1'b0, 1'b0},
    '{8'h00,    1'b0, 1'b1, mtt_pkg::KIND_OTHER,  8'd1, 32'sd0, 1'b0, 1'b0},
    '{8'hFF,    1'b0, 1'b1, mtt_pkg::KIND_OTHER,  8'd1, 32'sd0, 1'b0, 1'b0},
    '{CH_QUOTE, 1'b0, 1'b0, mtt_pkg::KIND_INT,    8'd0, 32'sd0, 1'b0, 1'b0},
    '{"a",      1'b0, 1'b0, mtt_pkg::KIND_INT,    8'd0, 32'sd0, 1'b0, 1'b0},
    '{CH_QUOTE, 1'b0, 1'b1, mtt_pkg::KIND_STRING, 8'd1, 32'sd0, 1'b0, 1'b0},
    // bare minus is an int of zero
    '{"-",      1'b0, 1'b0, mtt_pkg::KIND_INT,    8'd0, 32'sd0, 1'b0, 1'b0},
    '{" ",      1'b0, 1'b1, mtt_pkg::KIND_INT,    8'd1, 32'sd0, 1'b0, 1'b0},
    // lone slash, then an identifier ended by a dot
    '{"/",      1'b0, 1'b0, mtt_pkg::KIND_INT,    8'd0, 32'sd0, 1'b0, 1'b0},
    '{"x",      1'b0, 1'b0, mtt_pkg::KIND_INT,    8'd0, 32'sd0, 1'b0, 1'b0},
    '{".",      1'b0, 1'b0, mtt_pkg::KIND_INT,    8'd0, 32'sd0, 1'b0, 1'b0},
    // block comment closed right after a doubled star
    '{"/",      1'b0, 1'b0, mtt_pkg::KIND_INT,    8'd0, 32'sd0, 1'b0, 1'b0},
    '{"*",      1'b0, 1'b0, mtt_pkg::KIND_INT,    8'd0, 32'sd0, 1'b0, 1'b0},
    '{"*",      1'b0, 1'b0, mtt_pkg::KIND_INT,    8'd0, 32'sd0, 1'b0, 1'b0},
    '{"/",      1'b0, 1'b0, mtt_pkg::KIND_INT,    8'd0, 32'sd0, 1'b0, 1'b0},
    '{"/",      1'b0, 1'b0, mtt_pkg::KIND_INT,    8'd0, 32'sd0, 1'b0, 1'b0},
    '{"/",      1'b0, 1'b0, mtt_pkg::KIND_INT,    8'd0, 32'sd0, 1'b0, 1'b0},
    '{"q",      1'b0, 1'b0, mtt_pkg::KIND_INT,    8'd0, 32'sd0, 1'b0, 1'b0},
    '{CH_LF,    1'b0, 1'b0, mtt_pkg::KIND_INT,    8'd0, 32'sd0, 1'b0, 1'b0},
    // open string flushed by the final byte
    '{CH_QUOTE, 1'b0, 1'b0, mtt_pkg::KIND_INT,    8'd0, 32'sd0, 1'b0, 1'b0},
    '{"z",      1'b1, 1'b1, mtt_pkg::KIND_UNTERM, 8'd1, 32'sd0, 1'b0, 1'b1},
    '{"7",      1'b1, 1'b1, mtt_pkg::KIND_INT,    8'd1, 32'sd7, 1'b0, 1'b1}
  };

  logic clk;
  logic rst;

  mtt_in_if  text_in();
  mtt_out_if token_out();

  map_text_tokenizer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .text_in   (text_in),
    .token_out (token_out)
  );

  // predictor state
  scan_e       lx_mode;
  int unsigned lx_len;
  logic [31:0] lx_mag;
  logic        lx_neg;
  logic        lx_sat;

  mtt_pkg::token_t step_toks [$];
  mtt_pkg::token_t token_q   [$];
  mtt_pkg::token_t pinned    [int];
  text_t           text_q    [$];

  bit failed      = 1'b0;
  int idle_cycles = 0;
  int seen_tokens = 0;
  int next_hold   = 120;
  int hold_left   = 0;
  int phase_left  = 0;
  int drain_style = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_word(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic void clear_token();
    lx_len = 0;
    lx_mag = '0;
    lx_neg = 1'b0;
    lx_sat = 1'b0;
  endfunction

  function automatic void emit_tok(logic [3:0] kind, int unsigned len, logic [31:0] val,
                                   logic flag);
    mtt_pkg::token_t t;
    t.token_kind    = kind;
    t.token_length  = len[7:0];
    t.int_value     = val;
    t.overflow_flag = flag;
    t.last_result   = 1'b0;
    step_toks = {step_toks, t};
  endfunction

  function automatic void grow_len(int unsigned limit);
    if (lx_len >= limit) lx_sat = 1'b1;
    else lx_len++;
  endfunction

  function automatic void add_digit(logic [7:0] c);
    logic [63:0] m;
    m = {32'd0, lx_mag} * 64'd10 + {56'd0, c} - 64'h30;
    if (m > 64'h8000_0000) begin
      m = 64'h8000_0000;
      lx_sat = 1'b1;
    end
    lx_mag = m[31:0];
  endfunction

  function automatic void close_number();
    logic [31:0] v;
    logic        f;
    if (lx_mode == SCAN_SIGN || lx_mode == SCAN_INT) begin
      f = lx_sat;
      if (lx_neg) begin
        v = 32'd0 - lx_mag;
      end else if (lx_mag > 32'h7FFF_FFFF) begin
        v = 32'h7FFF_FFFF;
        f = 1'b1;
      end else begin
        v = lx_mag;
      end
      emit_tok(mtt_pkg::KIND_INT, lx_len, v, f);
    end else begin
      emit_tok(mtt_pkg::KIND_FLOAT, lx_len, 32'd0, lx_sat);
    end
    clear_token();
    lx_mode = SCAN_NORMAL;
  endfunction

  function automatic void open_token(logic [7:0] c);
    clear_token();
    lx_mode = SCAN_NORMAL;
    if (!(c == " " || c == CH_TAB || c == CH_LF || c == CH_CR)) begin
      if (c == "/") lx_mode = SCAN_SLASH;
      else if (c == CH_QUOTE) lx_mode = SCAN_STRING;
      else if (is_word(c)) begin
        lx_mode = SCAN_IDENT;
        lx_len  = 1;
      end else if (c == "-") begin
        lx_mode = SCAN_SIGN;
        lx_len  = 1;
        lx_neg  = 1'b1;
      end else if (is_digit(c)) begin
        lx_mode = SCAN_INT;
        lx_len  = 1;
        lx_mag  = {24'd0, c - 8'h30};
      end
      else if (c == "{") emit_tok(mtt_pkg::KIND_LBRACE, 1, 32'd0, 1'b0);
      else if (c == "}") emit_tok(mtt_pkg::KIND_RBRACE, 1, 32'd0, 1'b0);
      else if (c == "(") emit_tok(mtt_pkg::KIND_LPAREN, 1, 32'd0, 1'b0);
      else if (c == ")") emit_tok(mtt_pkg::KIND_RPAREN, 1, 32'd0, 1'b0);
      else emit_tok(mtt_pkg::KIND_OTHER, 1, 32'd0, 1'b0);
    end
  endfunction

  // Scan one byte; the records it causes land in step_toks.
  function automatic void tokenize_byte(logic [7:0] c, logic last);
    step_toks.delete();
    case (lx_mode)
      SCAN_SLASH: begin
        if (c == "/") lx_mode = SCAN_LINE;
        else if (c == "*") lx_mode = SCAN_BLOCK;
        else begin
          emit_tok(mtt_pkg::KIND_OTHER, 1, 32'd0, 1'b0);
          open_token(c);
        end
      end
      SCAN_LINE: begin
        if (c == CH_LF) lx_mode = SCAN_NORMAL;
      end
      SCAN_BLOCK: begin
        if (c == "*") lx_mode = SCAN_BLOCK_STAR;
      end
      SCAN_BLOCK_STAR: begin
        if (c == "/") lx_mode = SCAN_NORMAL;
        else if (c != "*") lx_mode = SCAN_BLOCK;
      end
      SCAN_STRING: begin
        if (c == CH_QUOTE) begin
          emit_tok(mtt_pkg::KIND_STRING, lx_len, 32'd0, lx_sat);
          clear_token();
          lx_mode = SCAN_NORMAL;
        end else begin
          grow_len(MAX_STR);
        end
      end
      SCAN_IDENT: begin
        if (is_word(c) || is_digit(c)) grow_len(MAX_ID);
        else begin
          emit_tok(mtt_pkg::KIND_IDENT, lx_len, 32'd0, lx_sat);
          open_token(c);
        end
      end
      SCAN_SIGN, SCAN_INT: begin
        if (is_digit(c)) begin
          lx_mode = SCAN_INT;
          add_digit(c);
          grow_len(MAX_NUM);
        end else if (c == ".") begin
          lx_mode = SCAN_FRAC;
          grow_len(MAX_NUM);
        end else begin
          close_number();
          open_token(c);
        end
      end
      SCAN_FRAC: begin
        if (is_digit(c)) grow_len(MAX_NUM);
        else if (c == "e") begin
          lx_mode = SCAN_EXP;
          grow_len(MAX_NUM);
        end else begin
          close_number();
          open_token(c);
        end
      end
      SCAN_EXP: begin
        if (is_digit(c) || c == "-") begin
          lx_mode = SCAN_EXP_DIGIT;
          grow_len(MAX_NUM);
        end else begin
          close_number();
          open_token(c);
        end
      end
      SCAN_EXP_DIGIT: begin
        if (is_digit(c)) grow_len(MAX_NUM);
        else begin
          close_number();
          open_token(c);
        end
      end
      default: open_token(c);
    endcase
    if (last) begin
      // flush whatever is still open, then start over
      case (lx_mode)
        SCAN_SLASH: emit_tok(mtt_pkg::KIND_OTHER, 1, 32'd0, 1'b0);
        SCAN_STRING: emit_tok(mtt_pkg::KIND_UNTERM, lx_len, 32'd0, lx_sat);
        SCAN_BLOCK, SCAN_BLOCK_STAR: emit_tok(mtt_pkg::KIND_UNTERM, 0, 32'd0, 1'b0);
        SCAN_IDENT: emit_tok(mtt_pkg::KIND_IDENT, lx_len, 32'd0, lx_sat);
        SCAN_SIGN, SCAN_INT, SCAN_FRAC, SCAN_EXP, SCAN_EXP_DIGIT: close_number();
        default: ;
      endcase
      if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last_result = 1'b1;
      clear_token();
      lx_mode = SCAN_NORMAL;
    end
  endfunction

  function automatic void put(logic [7:0] c);
    text_t t;
    t.c    = c;
    t.last = 1'b0;
    text_q = {text_q, t};
  endfunction

  function automatic void mark_last();
    text_q[text_q.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'h61 + 8'(r);
    else if (r < 52) return 8'h41 + 8'(r - 26);
    else return "_";
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(0, 3))
      0: return " ";
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic void put_digits(int n);
    repeat (n) put(rand_digit());
  endfunction

  // Mostly well-formed text with random content, plus noise and cut-off tokens.
  function automatic void make_random_text();
    string int_edges [8] = '{"2147483647", "2147483648", "-2147483648", "-2147483649",
                             "4294967296", "99999999999", "0", "-0"};
    string s;
    int    start;
    int    n_words;
    int    pick;
    int    len;
    logic [7:0] b;
    start   = text_q.size();
    n_words = 0;
    while (text_q.size() - start < RANDOM_ITEMS) begin
      n_words++;
      pick = (n_words % 50 == 0) ? 100 + (n_words / 50) % 3 : $urandom_range(0, 99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 3)) put(rand_space());
      end else if (pick < 26) begin
        if ($urandom_range(0, 2) == 0) put("-");
        put_digits($urandom_range(1, ($urandom_range(0, 3) == 0) ? 11 : 4));
      end else if (pick < 36) begin
        if ($urandom_range(0, 3) == 0) put("-");
        put_digits($urandom_range(0, 3));
        put(".");
        put_digits($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 0) begin
          put("e");
          if ($urandom_range(0, 1) == 0) put("-");
          put_digits($urandom_range(0, 2));
        end
      end else if (pick < 46) begin
        put(CH_QUOTE);
        repeat ($urandom_range(0, 12)) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
          put(b);
        end
        if ($urandom_range(0, 9) == 0) mark_last();
        else put(CH_QUOTE);
      end else if (pick < 60) begin
        put(rand_letter());
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
        repeat (len) put(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter());
      end else if (pick < 68) begin
        case ($urandom_range(0, 3))
          0: put("{");
          1: put("}");
          2: put("(");
          default: put(")");
        endcase
      end else if (pick < 73) begin
        put("/");
        put("/");
        repeat ($urandom_range(0, 10)) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
          put(b);
        end
        if ($urandom_range(0, 7) == 0) mark_last();
        else put(CH_LF);
      end else if (pick < 79) begin
        put("/");
        put("*");
        repeat ($urandom_range(0, 12)) put(($urandom_range(0, 2) == 0) ? "*" :
                                           8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0) mark_last();
        else begin
          put("*");
          put("/");
        end
      end else if (pick < 83) begin
        put("/");
      end else if (pick < 88) begin
        s = int_edges[$urandom_range(0, 7)];
        foreach (s[k]) put(s[k]);
      end else if (pick < 100) begin
        repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)));
      end else if (pick == 100) begin
        // string body near and past its length limit
        put(CH_QUOTE);
        repeat ($urandom_range(254, 262)) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
          put(b);
        end
        put(CH_QUOTE);
      end else if (pick == 101) begin
        if ($urandom_range(0, 1) == 0) put("-");
        put_digits($urandom_range(254, 262));
      end else begin
        put(rand_digit());
        put(".");
        put_digits($urandom_range(250, 258));
      end
      if ($urandom_range(0, 1) == 0) put(rand_space());
      if ($urandom_range(0, 24) == 0) mark_last();
    end
  endfunction

  task automatic feed_text();
    int i;
    int burst;
    int gap;
    i = 0;
    while (i < text_q.size()) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
      while (burst > 0 && i < text_q.size()) begin
        text_in.valid     <= 1'b1;
        text_in.char_code <= text_q[i].c;
        text_in.last_char <= text_q[i].last;
        @(posedge clk);
        if (text_in.ready) begin
          tokenize_byte(text_q[i].c, text_q[i].last);
          if (pinned.exists(i)) token_q = {token_q, pinned[i]};
          else foreach (step_toks[k]) token_q = {token_q, step_toks[k]};
          i++;
          burst--;
        end
      end
      gap = $urandom_range(0, 6);
      if (gap > 0 && i < text_q.size()) begin
        text_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    text_in.valid <= 1'b0;
  endtask

  function automatic void check_field(string what, longint want, longint got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk) begin : check
    mtt_pkg::token_t got;
    mtt_pkg::token_t want;
    if (!rst && token_out.valid && token_out.ready) begin
      got = {token_out.token_kind, token_out.token_length, token_out.int_value,
             token_out.overflow_flag, token_out.last_result};
      if (token_q.size() == 0) begin
        $display("%0t: unexpected token, expected none, got kind %0d length %0d value %0d",
                 $time, got.token_kind, got.token_length, got.int_value);
        failed = 1'b1;
      end else begin
        want = token_q.pop_front();
        check_field("token_kind", want.token_kind, got.token_kind);
        check_field("token_length", want.token_length, got.token_length);
        check_field("int_value", want.int_value, got.int_value);
        check_field("overflow_flag", want.overflow_flag, got.overflow_flag);
        check_field("last_result", want.last_result, got.last_result);
      end
    end
  end

  // Receiver: changing stall styles, plus a long hold-off so the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      token_out.ready <= 1'b0;
    end else begin
      if (token_out.valid && token_out.ready) seen_tokens++;
      if (hold_left == 0 && seen_tokens >= next_hold) begin
        hold_left = HOLD_CYCLES;
        next_hold = next_hold + 250;
      end
      if (phase_left == 0) begin
        drain_style = $urandom_range(0, 3);
        phase_left  = $urandom_range(8, 80);
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        token_out.ready <= 1'b0;
      end else begin
        case (drain_style)
          0: token_out.ready <= 1'b1;
          1: token_out.ready <= 1'($urandom_range(0, 1));
          2: token_out.ready <= ($urandom_range(0, 3) == 0);
          default: token_out.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (text_in.valid && text_in.ready) || (token_out.valid && token_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : main
    rst = 1'b1;
    text_in.valid     <= 1'b0;
    text_in.char_code <= 8'h00;
    text_in.last_char <= 1'b0;
    lx_mode = SCAN_NORMAL;
    clear_token();
    foreach (directed_tab[r]) begin
      put(directed_tab[r].c);
      text_q[text_q.size() - 1].last = directed_tab[r].last;
      if (directed_tab[r].pinned)
        pinned[text_q.size() - 1] = {directed_tab[r].kind, directed_tab[r].len,
                                     directed_tab[r].val, directed_tab[r].flag,
                                     directed_tab[r].lastr};
    end
    make_random_text();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    feed_text();
    while (token_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== map_text_tokenizer_unit.f =====
+incdir+hdl
hdl/mtt_pkg.sv
hdl/mtt_if.sv
hdl/mtt_scan.sv
hdl/mtt_fifo.sv
hdl/map_text_tokenizer_unit.sv
test/tb.sv
